>>> hw/rtl/vms_pkg.sv
// Shared constants and types for the voted mode sequencer.
package vms_pkg;

  localparam int WINDOW_LEN = 21;
  localparam int CNT_W      = $clog2(WINDOW_LEN + 1);
  localparam int VMIN_W     = 5;
  localparam int CMP_W      = (CNT_W > VMIN_W) ? CNT_W : VMIN_W;
  localparam int GEST_W     = 3;
  localparam int NUM_GEST   = 7;
  localparam int POS_W      = 16;
  localparam int TOL_W      = 10;
  localparam int SPD_W      = 15;
  localparam int ID_W       = 8;
  localparam int MODE_W     = 3;

  localparam logic [GEST_W-1:0] G_NONE    = 3'd0;
  localparam logic [GEST_W-1:0] G_HOVER   = 3'd1;
  localparam logic [GEST_W-1:0] G_TAKEOFF = 3'd2;
  localparam logic [GEST_W-1:0] G_LAND    = 3'd3;
  localparam logic [GEST_W-1:0] G_FOLLOW1 = 3'd4;
  localparam logic [GEST_W-1:0] G_FOLLOW2 = 3'd5;
  localparam logic [GEST_W-1:0] G_MISSION = 3'd6;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 15;

  localparam logic [CFG_IDX_W-1:0] CFG_VOTE_MIN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOL_X    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TOL_Y    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LEADER1  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LEADER2  = 3'd5;

  // per-gesture vote results for the beat being accepted
  typedef struct packed {
    logic hover;
    logic takeoff;
    logic land;
    logic follow1;
    logic follow2;
    logic mission;
  } vote_t;

endpackage

>>> hw/rtl/vms_hist_cell.sv
// One stage of the gesture history shift line.
module vms_hist_cell
  import vms_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              shift_i,
  input  logic [GEST_W-1:0] gest_i,
  output logic [GEST_W-1:0] gest_o
);

  logic [GEST_W-1:0] gest_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gest_q <= G_NONE;
    end else if (shift_i) begin
      gest_q <= gest_i;
    end
  end

  assign gest_o = gest_q;

endmodule

>>> hw/rtl/vms_vote_ctr.sv
// Running window count for one gesture code and its vote compare.
module vms_vote_ctr
  import vms_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [GEST_W-1:0] code_i,
  input  logic              shift_i,
  input  logic [GEST_W-1:0] new_i,
  input  logic [GEST_W-1:0] old_i,
  input  logic [VMIN_W-1:0] vmin_i,
  output logic              voted_o
);

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             inc, dec;

  assign inc   = (new_i == code_i);
  assign dec   = (old_i == code_i);
  // entering and leaving the window cancel out when both match
  assign cnt_d = cnt_q + CNT_W'(inc) - CNT_W'(dec);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (shift_i) begin
      cnt_q <= cnt_d;
    end
  end

  // vote uses the count after this beat enters the window
  assign voted_o = CMP_W'(cnt_d) >= CMP_W'(vmin_i);

endmodule

>>> hw/rtl/vms_seq.sv
// Flight mode machine, leader selection and the output register.
module vms_seq
  import vms_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    accept_i,
  input  vote_t                   vote_i,
  input  logic                    emergency_i,
  input  logic signed [POS_W-1:0] frame_x_i,
  input  logic signed [POS_W-1:0] frame_y_i,
  input  logic signed [POS_W-1:0] target_x_i,
  input  logic signed [POS_W-1:0] target_y_i,
  input  logic signed [POS_W-1:0] vel_x_i,
  input  logic signed [POS_W-1:0] vel_y_i,
  input  logic                    object_found_i,
  input  logic [TOL_W-1:0]        tol_x_i,
  input  logic [TOL_W-1:0]        tol_y_i,
  input  logic [SPD_W-1:0]        speed_limit_i,
  input  logic [ID_W-1:0]         leader_one_i,
  input  logic [ID_W-1:0]         leader_two_i,
  input  logic                    out_stall_i,
  output logic                    out_valid_o,
  output logic [MODE_W-1:0]       mode_o,
  output logic                    takeoff_pulse_o,
  output logic                    land_pulse_o,
  output logic                    camera_toggle_o,
  output logic                    detect_request_o,
  output logic [ID_W-1:0]         leader_out_o,
  output logic                    leader_update_o
);

  typedef enum logic [MODE_W-1:0] {
    M_LANDED  = 3'd0,
    M_HOVER   = 3'd1,
    M_FOLLOW  = 3'd2,
    M_MISSION = 3'd3,
    M_EMERG   = 3'd4
  } mode_e;

  localparam int MAG_W = POS_W + 1;

  mode_e            mode_q, mode_d;
  logic [ID_W-1:0]  leader_q, leader_d;
  logic             valid_q;
  logic             tk_q, ld_q, cam_q, det_q, lupd_q;
  logic             tk_d, ld_d, cam_d, det_d, lupd_d;

  logic signed [MAG_W-1:0] dx, dy, vx, vy;
  logic [MAG_W-1:0]        mag_dx, mag_dy, mag_vx, mag_vy;
  logic                    aligned;

  assign dx = MAG_W'(frame_x_i) - MAG_W'(target_x_i);
  assign dy = MAG_W'(frame_y_i) - MAG_W'(target_y_i);
  assign vx = MAG_W'(vel_x_i);
  assign vy = MAG_W'(vel_y_i);

  // 17-bit two's complement magnitude always fits unsigned
  assign mag_dx = dx[MAG_W-1] ? MAG_W'(-dx) : MAG_W'(dx);
  assign mag_dy = dy[MAG_W-1] ? MAG_W'(-dy) : MAG_W'(dy);
  assign mag_vx = vx[MAG_W-1] ? MAG_W'(-vx) : MAG_W'(vx);
  assign mag_vy = vy[MAG_W-1] ? MAG_W'(-vy) : MAG_W'(vy);

  assign aligned = (mag_dx <= MAG_W'(tol_x_i)) && (mag_dy <= MAG_W'(tol_y_i)) &&
                   (mag_vx <  MAG_W'(speed_limit_i)) &&
                   (mag_vy <  MAG_W'(speed_limit_i));

  always_comb begin
    mode_d   = mode_q;
    leader_d = leader_q;
    tk_d     = 1'b0;
    ld_d     = 1'b0;
    cam_d    = 1'b0;
    det_d    = 1'b0;
    lupd_d   = 1'b0;
    case (mode_q)
      M_LANDED: begin
        if (emergency_i) begin
          mode_d = M_EMERG;
        end else if (vote_i.takeoff) begin
          mode_d = M_HOVER;
          tk_d   = 1'b1;
        end else begin
          leader_d = leader_one_i;
          lupd_d   = 1'b1;
        end
      end
      M_HOVER: begin
        if (emergency_i) begin
          mode_d = M_EMERG;
        end else if (vote_i.follow1) begin
          mode_d   = M_FOLLOW;
          leader_d = leader_one_i;
          lupd_d   = 1'b1;
        end else if (vote_i.follow2) begin
          mode_d   = M_FOLLOW;
          leader_d = leader_two_i;
          lupd_d   = 1'b1;
        end else if (vote_i.land) begin
          mode_d = M_LANDED;
          ld_d   = 1'b1;
        end
      end
      M_FOLLOW: begin
        if (emergency_i) begin
          mode_d = M_EMERG;
        end else if (vote_i.hover) begin
          mode_d = M_HOVER;
        end else if (vote_i.land) begin
          mode_d = M_LANDED;
          ld_d   = 1'b1;
        end else if (vote_i.mission) begin
          mode_d = M_MISSION;
          cam_d  = 1'b1;
        end
      end
      M_MISSION: begin
        if (emergency_i) begin
          mode_d = M_EMERG;
        end else if (aligned) begin
          det_d  = 1'b1;
          cam_d  = 1'b1;
          mode_d = object_found_i ? M_HOVER : M_FOLLOW;
        end else if (vote_i.land) begin
          mode_d = M_LANDED;
          ld_d   = 1'b1;
        end
      end
      default: begin
        // emergency exits only on a voted land, with no land pulse
        mode_d = vote_i.land ? M_LANDED : M_EMERG;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= M_LANDED;
      leader_q <= '0;
      valid_q  <= 1'b0;
      tk_q     <= 1'b0;
      ld_q     <= 1'b0;
      cam_q    <= 1'b0;
      det_q    <= 1'b0;
      lupd_q   <= 1'b0;
    end else if (accept_i) begin
      mode_q   <= mode_d;
      leader_q <= leader_d;
      valid_q  <= 1'b1;
      tk_q     <= tk_d;
      ld_q     <= ld_d;
      cam_q    <= cam_d;
      det_q    <= det_d;
      lupd_q   <= lupd_d;
    end else if (!out_stall_i) begin
      valid_q  <= 1'b0;
    end
  end

  assign out_valid_o      = valid_q;
  assign mode_o           = mode_q;
  assign takeoff_pulse_o  = tk_q;
  assign land_pulse_o     = ld_q;
  assign camera_toggle_o  = cam_q;
  assign detect_request_o = det_q;
  assign leader_out_o     = leader_q;
  assign leader_update_o  = lupd_q;

  a_takeoff_hover: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && tk_q) |-> (mode_q == M_HOVER))
    else $error("takeoff pulse without hovering mode");

  a_detect_cam: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && det_q) |-> (cam_q && (mode_q == M_HOVER || mode_q == M_FOLLOW)))
    else $error("detect request without camera toggle or mission exit");

  a_land_landed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && ld_q) |-> (mode_q == M_LANDED && !tk_q))
    else $error("land pulse outside landed mode");

  a_leader_upd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && lupd_q) |-> (mode_q == M_LANDED || mode_q == M_FOLLOW))
    else $error("leader written in wrong mode");

  a_leader_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!accept_i && $past(rst_ni)) |=> $stable(leader_q))
    else $error("leader changed without an accepted beat");

endmodule

>>> hw/rtl/voted_mode_sequencer.sv
// Top level of the voted mode sequencer: config registers, history chain, vote counters.
//
// Usage: one control tick per input beat. The input channel (in_valid_i / in_stall_o)
// carries the gesture code, emergency flag, frame and target positions, velocities and
// the detector answer. Each accepted beat yields exactly one result beat on the output
// channel (out_valid_o / out_stall_i): the new flight mode, the takeoff, land,
// camera-toggle, detect-request and leader-update flags, and the selected leader.
// The result is registered: the result of a beat accepted at one edge is valid from that
// edge on. Throughput is one beat per cycle while no held result is stalled; the gesture
// history is a 21-stage shift chain with one running counter per gesture code except the
// no-gesture code, so voting and the mode decision finish in the accepting cycle.
// The output register holds its beat while out_stall_i is high; in_stall_o is raised
// only while a held result is stalled, and a beat is accepted in the same cycle the
// held result is taken. Config writes (cfg_valid_i / cfg_ready_o, index and data) are
// taken in every cycle and should be issued only while the block is idle.
// Reset fills the history with the no-gesture code, clears the counts, selects landed
// mode and leader zero, and loads the documented register defaults.
module voted_mode_sequencer
  import vms_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [GEST_W-1:0]       gesture_i,
  input  logic                    emergency_i,
  input  logic signed [POS_W-1:0] frame_x_i,
  input  logic signed [POS_W-1:0] frame_y_i,
  input  logic signed [POS_W-1:0] target_x_i,
  input  logic signed [POS_W-1:0] target_y_i,
  input  logic signed [POS_W-1:0] vel_x_i,
  input  logic signed [POS_W-1:0] vel_y_i,
  input  logic                    object_found_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [MODE_W-1:0]       mode_o,
  output logic                    takeoff_pulse_o,
  output logic                    land_pulse_o,
  output logic                    camera_toggle_o,
  output logic                    detect_request_o,
  output logic [ID_W-1:0]         leader_out_o,
  output logic                    leader_update_o,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [CFG_DAT_W-1:0]    cfg_data_i
);

  localparam logic [VMIN_W-1:0] VMIN_RST  = 5'd19;
  localparam logic [TOL_W-1:0]  TOLX_RST  = 10'd50;
  localparam logic [TOL_W-1:0]  TOLY_RST  = 10'd100;
  localparam logic [SPD_W-1:0]  SPEED_RST = 15'd30;

  logic [VMIN_W-1:0] vmin_q;
  logic [TOL_W-1:0]  tol_x_q, tol_y_q;
  logic [SPD_W-1:0]  speed_q;
  logic [ID_W-1:0]   lead1_q, lead2_q;

  logic              accept;
  logic [GEST_W-1:0] gest_norm;
  logic [GEST_W-1:0] hist [WINDOW_LEN];
  logic [NUM_GEST-1:1] voted;
  vote_t             vote;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vmin_q  <= VMIN_RST;
      tol_x_q <= TOLX_RST;
      tol_y_q <= TOLY_RST;
      speed_q <= SPEED_RST;
      lead1_q <= '0;
      lead2_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_VOTE_MIN: vmin_q  <= cfg_data_i[VMIN_W-1:0];
        CFG_TOL_X:    tol_x_q <= cfg_data_i[TOL_W-1:0];
        CFG_TOL_Y:    tol_y_q <= cfg_data_i[TOL_W-1:0];
        CFG_SPEED:    speed_q <= cfg_data_i[SPD_W-1:0];
        CFG_LEADER1:  lead1_q <= cfg_data_i[ID_W-1:0];
        CFG_LEADER2:  lead2_q <= cfg_data_i[ID_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_stall_o = out_valid_o && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  // the unused code seven counts as no gesture
  assign gest_norm = (gesture_i > G_MISSION) ? G_NONE : gesture_i;

  for (genvar k = 0; k < WINDOW_LEN; k++) begin : g_hist
    if (k == 0) begin : g_head
      vms_hist_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (accept),
        .gest_i  (gest_norm),
        .gest_o  (hist[k])
      );
    end else begin : g_body
      vms_hist_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (accept),
        .gest_i  (hist[k-1]),
        .gest_o  (hist[k])
      );
    end
  end

  // no counter for the idle code: nothing votes on it
  for (genvar c = 1; c < NUM_GEST; c++) begin : g_cnt
    vms_vote_ctr u_ctr (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .code_i  (GEST_W'(c)),
      .shift_i (accept),
      .new_i   (gest_norm),
      .old_i   (hist[WINDOW_LEN-1]),
      .vmin_i  (vmin_q),
      .voted_o (voted[c])
    );
  end

  assign vote.hover   = voted[G_HOVER];
  assign vote.takeoff = voted[G_TAKEOFF];
  assign vote.land    = voted[G_LAND];
  assign vote.follow1 = voted[G_FOLLOW1];
  assign vote.follow2 = voted[G_FOLLOW2];
  assign vote.mission = voted[G_MISSION];

  vms_seq u_seq (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .accept_i         (accept),
    .vote_i           (vote),
    .emergency_i      (emergency_i),
    .frame_x_i        (frame_x_i),
    .frame_y_i        (frame_y_i),
    .target_x_i       (target_x_i),
    .target_y_i       (target_y_i),
    .vel_x_i          (vel_x_i),
    .vel_y_i          (vel_y_i),
    .object_found_i   (object_found_i),
    .tol_x_i          (tol_x_q),
    .tol_y_i          (tol_y_q),
    .speed_limit_i    (speed_q),
    .leader_one_i     (lead1_q),
    .leader_two_i     (lead2_q),
    .out_stall_i      (out_stall_i),
    .out_valid_o      (out_valid_o),
    .mode_o           (mode_o),
    .takeoff_pulse_o  (takeoff_pulse_o),
    .land_pulse_o     (land_pulse_o),
    .camera_toggle_o  (camera_toggle_o),
    .detect_request_o (detect_request_o),
    .leader_out_o     (leader_out_o),
    .leader_update_o  (leader_update_o)
  );

endmodule

>>> test/voted_mode_sequencer_tb.sv
// Self-checking testbench for the voted mode sequencer: gesture voting and flight modes.
module voted_mode_sequencer_tb;
  import vms_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int SQUEEZE_CYCLES = 150;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  typedef enum logic [MODE_W-1:0] {
    M_LANDED  = 3'd0,
    M_HOVER   = 3'd1,
    M_FOLLOW  = 3'd2,
    M_MISSION = 3'd3,
    M_EMERG   = 3'd4
  } flight_mode_e;

  typedef struct {
    logic [GEST_W-1:0]       gesture;
    logic                    emergency;
    logic signed [POS_W-1:0] fx;
    logic signed [POS_W-1:0] fy;
    logic signed [POS_W-1:0] tx;
    logic signed [POS_W-1:0] ty;
    logic signed [POS_W-1:0] vx;
    logic signed [POS_W-1:0] vy;
    logic                    found;
  } tick_in_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              takeoff;
    logic              land;
    logic              camera;
    logic              detect;
    logic [ID_W-1:0]   leader;
    logic              lupd;
  } cmd_t;

  // Mirror of the sequencer: vote window, running tallies, mode and leader.
  class flight_cmd_board;
    int unsigned vote_min, tol_x, tol_y, speed, lead_one, lead_two;
    logic [GEST_W-1:0] window [WINDOW_LEN];
    int win_pos;
    int tally [NUM_GEST];
    flight_mode_e flight;
    logic [ID_W-1:0] leader;
    cmd_t pending_cmds [$];
    int errors, checked, ticks;
    int mode_hits [5];
    int pulse_hits [4];

    function new();
      vote_min = 19;
      tol_x    = 50;
      tol_y    = 100;
      speed    = 30;
      lead_one = 0;
      lead_two = 0;
      foreach (window[i]) window[i] = G_NONE;
      foreach (tally[i]) tally[i] = 0;
      tally[G_NONE] = WINDOW_LEN;
      win_pos = 0;
      flight  = M_LANDED;
      leader  = '0;
      errors  = 0;
      checked = 0;
      ticks   = 0;
      foreach (mode_hits[i]) mode_hits[i] = 0;
      foreach (pulse_hits[i]) pulse_hits[i] = 0;
    endfunction

    function logic [CFG_DAT_W-1:0] reg_mask(logic [CFG_IDX_W-1:0] idx);
      case (idx)
        CFG_VOTE_MIN:         return 15'h001F;
        CFG_TOL_X, CFG_TOL_Y: return 15'h03FF;
        CFG_SPEED:            return 15'h7FFF;
        CFG_LEADER1,
        CFG_LEADER2:          return 15'h00FF;
        default:              return 15'h0000;
      endcase
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
      int unsigned v;
      v = 32'(data & reg_mask(idx));
      case (idx)
        CFG_VOTE_MIN: vote_min = v;
        CFG_TOL_X:    tol_x    = v;
        CFG_TOL_Y:    tol_y    = v;
        CFG_SPEED:    speed    = v;
        CFG_LEADER1:  lead_one = v;
        CFG_LEADER2:  lead_two = v;
        default: ;
      endcase
    endfunction

    function bit voted(logic [GEST_W-1:0] g);
      return tally[g] >= int'(vote_min);
    endfunction

    function void note_tick(tick_in_t t);
      logic [GEST_W-1:0] g, old;
      cmd_t c;
      int dx, dy, ax, ay;
      bit aligned;
      // code seven counts as no gesture
      g = (t.gesture > G_MISSION) ? G_NONE : t.gesture;
      old = window[win_pos];
      if (tally[old] > 0) tally[old]--;
      window[win_pos] = g;
      tally[g]++;
      win_pos = (win_pos + 1) % WINDOW_LEN;

      dx = int'(t.fx) - int'(t.tx);
      dy = int'(t.fy) - int'(t.ty);
      ax = int'(t.vx);
      ay = int'(t.vy);
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      if (ax < 0) ax = -ax;
      if (ay < 0) ay = -ay;
      aligned = dx <= int'(tol_x) && dy <= int'(tol_y) &&
                ax < int'(speed) && ay < int'(speed);

      c = '0;
      case (flight)
        M_LANDED: begin
          if (t.emergency) flight = M_EMERG;
          else if (voted(G_TAKEOFF)) begin
            flight = M_HOVER;
            c.takeoff = 1'b1;
          end else begin
            leader = lead_one[ID_W-1:0];
            c.lupd = 1'b1;
          end
        end
        M_HOVER: begin
          if (t.emergency) flight = M_EMERG;
          else if (voted(G_FOLLOW1)) begin
            flight = M_FOLLOW;
            leader = lead_one[ID_W-1:0];
            c.lupd = 1'b1;
          end else if (voted(G_FOLLOW2)) begin
            flight = M_FOLLOW;
            leader = lead_two[ID_W-1:0];
            c.lupd = 1'b1;
          end else if (voted(G_LAND)) begin
            flight = M_LANDED;
            c.land = 1'b1;
          end
        end
        M_FOLLOW: begin
          if (t.emergency) flight = M_EMERG;
          else if (voted(G_HOVER)) flight = M_HOVER;
          else if (voted(G_LAND)) begin
            flight = M_LANDED;
            c.land = 1'b1;
          end else if (voted(G_MISSION)) begin
            flight = M_MISSION;
            c.camera = 1'b1;
          end
        end
        M_MISSION: begin
          if (t.emergency) flight = M_EMERG;
          else if (aligned) begin
            c.detect = 1'b1;
            c.camera = 1'b1;
            flight = t.found ? M_HOVER : M_FOLLOW;
          end else if (voted(G_LAND)) begin
            flight = M_LANDED;
            c.land = 1'b1;
          end
        end
        default: begin
          // leaving emergency gives no land pulse
          flight = voted(G_LAND) ? M_LANDED : M_EMERG;
        end
      endcase
      c.mode   = flight;
      c.leader = leader;
      pending_cmds.push_back(c);
      ticks++;
    endfunction

    function string fmt(cmd_t c);
      return $sformatf("mode %0d to %0b ld %0b cam %0b det %0b leader %0d upd %0b",
                       c.mode, c.takeoff, c.land, c.camera, c.detect, c.leader, c.lupd);
    endfunction

    function void check_cmd(cmd_t got);
      cmd_t want;
      if (pending_cmds.size() == 0) begin
        errors++;
        if (errors <= 10) $display("ERROR: command beat with none pending: %s", fmt(got));
        return;
      end
      want = pending_cmds.pop_front();
      checked++;
      if (want.mode <= M_EMERG) mode_hits[want.mode]++;
      if (want.takeoff) pulse_hits[0]++;
      if (want.land) pulse_hits[1]++;
      if (want.camera) pulse_hits[2]++;
      if (want.detect) pulse_hits[3]++;
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: beat %0d expected %s, got %s", checked, fmt(want), fmt(got));
      end
    endfunction
  endclass

  logic                    clk_i;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_stall_o;
  logic [GEST_W-1:0]       gesture_i;
  logic                    emergency_i;
  logic signed [POS_W-1:0] frame_x_i;
  logic signed [POS_W-1:0] frame_y_i;
  logic signed [POS_W-1:0] target_x_i;
  logic signed [POS_W-1:0] target_y_i;
  logic signed [POS_W-1:0] vel_x_i;
  logic signed [POS_W-1:0] vel_y_i;
  logic                    object_found_i;
  logic                    out_valid_o;
  logic                    out_stall_i;
  logic [MODE_W-1:0]       mode_o;
  logic                    takeoff_pulse_o;
  logic                    land_pulse_o;
  logic                    camera_toggle_o;
  logic                    detect_request_o;
  logic [ID_W-1:0]         leader_out_o;
  logic                    leader_update_o;
  logic                    cfg_valid_i;
  logic                    cfg_ready_o;
  logic [CFG_IDX_W-1:0]    cfg_index_i;
  logic [CFG_DAT_W-1:0]    cfg_data_i;

  flight_cmd_board board;
  logic calm;
  logic squeeze_req;
  int   settings;
  int   idle_cycles;

  voted_mode_sequencer dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .gesture_i        (gesture_i),
    .emergency_i      (emergency_i),
    .frame_x_i        (frame_x_i),
    .frame_y_i        (frame_y_i),
    .target_x_i       (target_x_i),
    .target_y_i       (target_y_i),
    .vel_x_i          (vel_x_i),
    .vel_y_i          (vel_y_i),
    .object_found_i   (object_found_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .mode_o           (mode_o),
    .takeoff_pulse_o  (takeoff_pulse_o),
    .land_pulse_o     (land_pulse_o),
    .camera_toggle_o  (camera_toggle_o),
    .detect_request_o (detect_request_o),
    .leader_out_o     (leader_out_o),
    .leader_update_o  (leader_update_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always #5ns clk_i = ~clk_i;

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic tick_in_t mk(logic [GEST_W-1:0] g, logic em,
                                  int fx, int fy, int tx, int ty,
                                  int vx, int vy, logic found);
    tick_in_t t;
    t.gesture   = g;
    t.emergency = em;
    t.fx        = fx[POS_W-1:0];
    t.fy        = fy[POS_W-1:0];
    t.tx        = tx[POS_W-1:0];
    t.ty        = ty[POS_W-1:0];
    t.vx        = vx[POS_W-1:0];
    t.vy        = vy[POS_W-1:0];
    t.found     = found;
    return t;
  endfunction

  // positions and speeds cluster around the current tolerances so missions can finish
  function automatic tick_in_t make_tick(logic [GEST_W-1:0] g);
    tick_in_t t;
    int off, sum;
    t.gesture   = g;
    t.emergency = ($urandom_range(0, 199) < 2);
    t.found     = 1'($urandom_range(0, 1));
    t.fx        = POS_W'($urandom);
    t.fy        = POS_W'($urandom);
    t.tx        = POS_W'($urandom);
    t.ty        = POS_W'($urandom);
    t.vx        = POS_W'($urandom);
    t.vy        = POS_W'($urandom);
    if ($urandom_range(0, 9) < 7) begin
      off  = int'($urandom_range(0, 2 * board.tol_x + 4)) - int'(board.tol_x) - 2;
      sum  = int'(t.fx) - off;
      t.tx = sum[POS_W-1:0];
      off  = int'($urandom_range(0, 2 * board.tol_y + 4)) - int'(board.tol_y) - 2;
      sum  = int'(t.fy) - off;
      t.ty = sum[POS_W-1:0];
    end
    if ($urandom_range(0, 9) < 7) begin
      off  = int'($urandom_range(0, 2 * board.speed + 2)) - int'(board.speed) - 1;
      t.vx = off[POS_W-1:0];
      off  = int'($urandom_range(0, 2 * board.speed + 2)) - int'(board.speed) - 1;
      t.vy = off[POS_W-1:0];
    end
    return t;
  endfunction

  // gesture that pushes the predicted mode one step further
  function automatic logic [GEST_W-1:0] next_gesture();
    int r;
    r = $urandom_range(0, 99);
    case (board.flight)
      M_LANDED:  return G_TAKEOFF;
      M_HOVER:   return (r < 45) ? G_FOLLOW1 : (r < 90) ? G_FOLLOW2 : G_LAND;
      M_FOLLOW:  return (r < 70) ? G_MISSION : (r < 85) ? G_HOVER : G_LAND;
      M_MISSION: return (r < 75) ? G_MISSION : G_LAND;
      default:   return G_LAND;
    endcase
  endfunction

  task automatic send_tick(tick_in_t t);
    int gap;
    gap = calm ? 0 : gap_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    gesture_i      <= t.gesture;
    emergency_i    <= t.emergency;
    frame_x_i      <= t.fx;
    frame_y_i      <= t.fy;
    target_x_i     <= t.tx;
    target_y_i     <= t.ty;
    vel_x_i        <= t.vx;
    vel_y_i        <= t.vy;
    object_found_i <= t.found;
    in_valid_i     <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    board.note_tick(t);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (board.pending_cmds.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, int unsigned val, bit junk);
    logic [CFG_DAT_W-1:0] d, m;
    m = board.reg_mask(idx);
    d = val[CFG_DAT_W-1:0] & m;
    // upper bits beyond the register width must be dropped
    if (junk) d = d | (CFG_DAT_W'($urandom) & ~m);
    cfg_index_i <= idx;
    cfg_data_i  <= d;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.set_reg(idx, d);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_config(int unsigned vmin, int unsigned tx, int unsigned ty,
                            int unsigned sp, int unsigned l1, int unsigned l2, bit junk);
    drain();
    cfg_write(CFG_VOTE_MIN, vmin, junk);
    cfg_write(CFG_TOL_X, tx, junk);
    cfg_write(CFG_TOL_Y, ty, junk);
    cfg_write(CFG_SPEED, sp, junk);
    cfg_write(CFG_LEADER1, l1, junk);
    cfg_write(CFG_LEADER2, l2, junk);
    settings++;
  endtask

  // runs of one gesture long enough to win the vote, with noise mixed in
  task automatic run_phase(int n, logic quiet);
    int sent, len;
    logic [GEST_W-1:0] g, gi;
    calm <= quiet;
    sent = 0;
    while (sent < n) begin
      g = ($urandom_range(0, 99) < 70) ? next_gesture() : GEST_W'($urandom_range(0, 7));
      if (board.vote_min > 0 && board.vote_min <= WINDOW_LEN)
        len = board.vote_min + $urandom_range(0, 6);
      else
        len = $urandom_range(1, 12);
      for (int i = 0; i < len && sent < n; i++) begin
        gi = ($urandom_range(0, 99) < 8) ? GEST_W'($urandom_range(0, 7)) : g;
        send_tick(make_tick(gi));
        sent++;
      end
    end
  endtask

  // result side: random stalls, one long hold-off to fill the block
  initial begin
    int n;
    bit squeezed;
    out_stall_i = 1'b0;
    squeezed = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (squeeze_req && !squeezed) begin
        squeezed = 1'b1;
        out_stall_i <= 1'b1;
        repeat (SQUEEZE_CYCLES) @(posedge clk_i);
        out_stall_i <= 1'b0;
        @(posedge clk_i);
      end else if (calm) begin
        out_stall_i <= 1'b0;
        @(posedge clk_i);
      end else begin
        n = gap_len();
        if (n == 0) begin
          out_stall_i <= 1'b0;
          @(posedge clk_i);
        end else begin
          out_stall_i <= 1'b1;
          repeat (n) @(posedge clk_i);
          out_stall_i <= 1'b0;
          @(posedge clk_i);
        end
      end
    end
  end

  // result checking and watchdog
  always @(posedge clk_i) begin
    cmd_t got;
    bit moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (out_valid_o && !out_stall_i) begin
        got.mode    = mode_o;
        got.takeoff = takeoff_pulse_o;
        got.land    = land_pulse_o;
        got.camera  = camera_toggle_o;
        got.detect  = detect_request_o;
        got.leader  = leader_out_o;
        got.lupd    = leader_update_o;
        board.check_cmd(got);
        moved = 1'b1;
      end
      if ((in_valid_i && !in_stall_o) || (cfg_valid_i && cfg_ready_o)) moved = 1'b1;
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("ERROR: no beat moved for %0d cycles", WATCHDOG_LIMIT);
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    board          = new();
    settings       = 1;
    idle_cycles    = 0;
    calm           = 1'b0;
    squeeze_req    = 1'b0;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    gesture_i      = G_NONE;
    emergency_i    = 1'b0;
    frame_x_i      = '0;
    frame_y_i      = '0;
    target_x_i     = '0;
    target_y_i     = '0;
    vel_x_i        = '0;
    vel_y_i        = '0;
    object_found_i = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = CFG_VOTE_MIN;
    cfg_data_i     = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset defaults: code seven is no gesture, then emergency from landed
    send_tick(mk(3'd7, 1'b0, 0, 0, 0, 0, 0, 0, 1'b0));
    send_tick(mk(G_NONE, 1'b1, 0, 0, 0, 0, 0, 0, 1'b0));
    send_tick(mk(G_NONE, 1'b0, 0, 0, 0, 0, 0, 0, 1'b0));

    // one vote is enough from here on
    set_config(1, 0, 1023, 32767, 8'hFF, 8'h00, 1'b0);
    send_tick(mk(G_LAND, 1'b0, 0, 0, 0, 0, 0, 0, 1'b0));
    send_tick(mk(G_TAKEOFF, 1'b0, 0, 0, 0, 0, 0, 0, 1'b0));
    send_tick(mk(G_FOLLOW1, 1'b0, 0, 0, 0, 0, 0, 0, 1'b0));
    send_tick(mk(G_MISSION, 1'b0, 0, 0, 0, 0, 0, 0, 1'b0));
    send_tick(mk(G_MISSION, 1'b0, 32767, 0, -32768, 0, 0, 0, 1'b1));
    send_tick(mk(G_MISSION, 1'b0, -32768, 32767, -32768, 32767 - 1023,
                 32766, -32767, 1'b1));
    send_tick(mk(G_FOLLOW2, 1'b0, 0, 0, 0, 0, 0, 0, 1'b0));
    send_tick(mk(G_MISSION, 1'b0, 0, 0, 0, 0, 0, 0, 1'b0));
    send_tick(mk(G_MISSION, 1'b0, 100, -100, 100, -100, -32768, 0, 1'b0));
    send_tick(mk(G_MISSION, 1'b0, 100, -100, 100, -1124, 0, 0, 1'b0));
    send_tick(mk(G_MISSION, 1'b0, 5, 5, 5, 5, 0, 0, 1'b0));
    send_tick(mk(G_LAND, 1'b0, 0, 0, 0, 0, 0, 0, 1'b0));
    send_tick(mk(G_HOVER, 1'b0, 0, 0, 0, 0, 0, 0, 1'b0));
    send_tick(mk(G_NONE, 1'b1, 0, 0, 0, 0, 0, 0, 1'b0));
    send_tick(mk(G_NONE, 1'b0, 0, 0, 0, 0, 0, 0, 1'b0));
    send_tick(mk(G_NONE, 1'b1, -1, -1, -1, -1, -1, -1, 1'b1));

    set_config(19, 50, 100, 30, 8'h11, 8'h22, 1'b0);
    run_phase(130, 1'b0);
    // threshold zero: every gesture votes, first test wins
    set_config(0, 0, 0, 0, 8'h00, 8'hFF, 1'b0);
    run_phase(80, 1'b0);
    set_config(WINDOW_LEN, 1023, 1023, 32767, 8'hFF, 8'h00, 1'b0);
    run_phase(100, 1'b1);
    // thresholds above the window never vote
    set_config(22, $urandom_range(0, 1023), $urandom_range(0, 1023),
               $urandom_range(0, 400), $urandom_range(0, 255), $urandom_range(0, 255), 1'b1);
    cfg_write(CFG_SPARE_LO, $urandom, 1'b1);
    cfg_write(CFG_SPARE_HI, $urandom, 1'b1);
    run_phase(60, 1'b0);
    set_config(31, $urandom_range(0, 1023), $urandom_range(0, 1023),
               $urandom_range(0, 32767), $urandom_range(0, 255), $urandom_range(0, 255), 1'b1);
    run_phase(60, 1'b0);
    for (int p = 0; p < 5; p++) begin
      set_config($urandom_range(1, 8), $urandom_range(0, 1023), $urandom_range(0, 1023),
                 ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32767) : $urandom_range(0, 400),
                 $urandom_range(0, 255), $urandom_range(0, 255), 1'b1);
      if (p == 0) squeeze_req <= 1'b1;
      run_phase(120, (p == 2));
    end

    drain();
    repeat (5) @(posedge clk_i);
    $display("Ran %0d ticks under %0d register settings, %0d command beats checked.",
             board.ticks, settings, board.checked);
    $display("Mode visits L/H/F/M/E %0d/%0d/%0d/%0d/%0d; takeoff %0d land %0d cam %0d det %0d.",
             board.mode_hits[0], board.mode_hits[1], board.mode_hits[2], board.mode_hits[3],
             board.mode_hits[4], board.pulse_hits[0], board.pulse_hits[1],
             board.pulse_hits[2], board.pulse_hits[3]);
    if (board.errors == 0 && board.pending_cmds.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("ERROR: %0d mismatches, %0d beats still pending",
               board.errors, board.pending_cmds.size());
      $display("Verification failed");
    end
    $finish;
  end

endmodule
